// ===== rtl/lmtc_pkg.sv =====
// Shared types and constants for the LCD mode timing controller.
// Used by lmtc_regs, lmtc_seq and lcd_mode_timing_controller; depends on nothing.
`default_nettype none

package lmtc_pkg;

  // Item kinds carried on in_tuser
  localparam logic [1:0] ACT_TICK  = 2'd0;
  localparam logic [1:0] ACT_WRITE = 2'd1;
  localparam logic [1:0] ACT_READ  = 2'd2;

  // Register map
  localparam logic [15:0] ADDR_LCDC = 16'hFF40;
  localparam logic [15:0] ADDR_STAT = 16'hFF41;
  localparam logic [15:0] ADDR_SCY  = 16'hFF42;
  localparam logic [15:0] ADDR_SCX  = 16'hFF43;
  localparam logic [15:0] ADDR_LY   = 16'hFF44;
  localparam logic [15:0] ADDR_LYC  = 16'hFF45;
  localparam logic [15:0] ADDR_BGP  = 16'hFF47;
  localparam logic [15:0] ADDR_OBP0 = 16'hFF48;
  localparam logic [15:0] ADDR_OBP1 = 16'hFF49;
  localparam logic [15:0] ADDR_WY   = 16'hFF4A;
  localparam logic [15:0] ADDR_WX   = 16'hFF4B;

  // Register reset values and read masks
  localparam logic [7:0] CONTROL_RESET = 8'h91;
  localparam logic [7:0] STATUS_RESET  = 8'h81;
  localparam logic [7:0] BGP_RESET     = 8'hE4;
  localparam logic [7:0] STAT_RMASK    = 8'h7C;
  localparam logic [7:0] STAT_FORCE    = 8'h80;
  localparam logic [7:0] UNMAPPED_DATA = 8'hFF;

  // Line kinds of the sequencer
  localparam logic [1:0] KIND_FIRST  = 2'd0;
  localparam logic [1:0] KIND_NORMAL = 2'd1;
  localparam logic [1:0] KIND_VBLANK = 2'd2;
  localparam logic [1:0] KIND_LAST   = 2'd3;

  // LCD modes
  localparam logic [1:0] MODE_HBLANK = 2'd0;
  localparam logic [1:0] MODE_VBLANK = 2'd1;
  localparam logic [1:0] MODE_OAM    = 2'd2;
  localparam logic [1:0] MODE_XFER   = 2'd3;

  // Countdown reloads (signed 16-bit countdown)
  localparam logic signed [15:0] CD_RESET  = 16'sd80;
  localparam logic signed [15:0] CD_OAM    = 16'sd80;
  localparam logic signed [15:0] CD_XFER   = 16'sd336;
  localparam logic signed [15:0] CD_HEND   = 16'sd32;
  localparam logic signed [15:0] CD_STEP   = 16'sd4;
  localparam logic signed [15:0] CD_LINE   = 16'sd452;
  localparam logic signed [15:0] CD_FLOOR  = 16'sh8000;

  // Line numbers
  localparam logic [7:0] LINE_VBLANK   = 8'd144;
  localparam logic [7:0] LINE_LAST_SEQ = 8'd153;
  localparam logic [7:0] SEQ_RESET     = 8'd154;

  // One input word
  typedef struct packed {
    logic [1:0]  action;
    logic [15:0] bus_address;
    logic [7:0]  write_data;
    logic [7:0]  tick_cycles;
  } item_t;

  // Registers the sequencer looks at
  typedef struct packed {
    logic [7:0] control;
    logic [7:0] status;
    logic [7:0] compare;
  } lcd_regs_t;

  // Sequencer state visible on register reads
  typedef struct packed {
    logic [7:0] line;
    logic [1:0] mode;
    logic       match;
  } seq_status_t;

  // Per-tick event flags
  typedef struct packed {
    logic       vblank_request;
    logic       stat_request;
    logic       render_request;
    logic [7:0] render_line;
    logic       frame_done;
  } tick_flags_t;

endpackage

`default_nettype wire

// ===== rtl/lmtc_regs.sv =====
// LCD register file (0xFF40..0xFF4B) with the bus read mux.
// Depends on lmtc_pkg; reads sequencer status from lmtc_seq.
`default_nettype none

module lmtc_regs (
  input  wire                      clk,
  input  wire                      rst_n,
  input  wire                      wr_en,
  input  wire [15:0]               addr,
  input  wire [7:0]                wdata,
  input  lmtc_pkg::seq_status_t    seq_status,
  output lmtc_pkg::lcd_regs_t      regs,
  output logic                     restart,
  output logic [7:0]               read_data
);

  logic [7:0] control_r, status_r, scy_r, scx_r, lyc_r;
  logic [7:0] bgp_r, obp0_r, obp1_r, wy_r, wx_r;

  // Display turning on restarts the line sequencer
  assign restart = wr_en && (addr == lmtc_pkg::ADDR_LCDC) && !control_r[7] && wdata[7];

  // Register writes; LY is read only
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      control_r <= lmtc_pkg::CONTROL_RESET;
      status_r  <= lmtc_pkg::STATUS_RESET;
      scy_r     <= 8'd0;
      scx_r     <= 8'd0;
      lyc_r     <= 8'd0;
      bgp_r     <= lmtc_pkg::BGP_RESET;
      obp0_r    <= 8'd0;
      obp1_r    <= 8'd0;
      wy_r      <= 8'd0;
      wx_r      <= 8'd0;
    end else if (wr_en) begin
      unique case (addr)
        lmtc_pkg::ADDR_LCDC: control_r <= wdata;
        lmtc_pkg::ADDR_STAT: status_r  <= wdata;
        lmtc_pkg::ADDR_SCY:  scy_r     <= wdata;
        lmtc_pkg::ADDR_SCX:  scx_r     <= wdata;
        lmtc_pkg::ADDR_LYC:  lyc_r     <= wdata;
        lmtc_pkg::ADDR_BGP:  bgp_r     <= wdata;
        lmtc_pkg::ADDR_OBP0: obp0_r    <= wdata;
        lmtc_pkg::ADDR_OBP1: obp1_r    <= wdata;
        lmtc_pkg::ADDR_WY:   wy_r      <= wdata;
        lmtc_pkg::ADDR_WX:   wx_r      <= wdata;
        default: ;
      endcase
    end
  end

  assign regs.control = control_r;
  assign regs.status  = status_r;
  assign regs.compare = lyc_r;

  // Read mux; unmapped addresses read as all ones
  always_comb begin
    unique case (addr)
      lmtc_pkg::ADDR_LCDC: read_data = control_r;
      lmtc_pkg::ADDR_STAT: read_data = (status_r & lmtc_pkg::STAT_RMASK)
                                       | {5'd0, seq_status.match, seq_status.mode}
                                       | lmtc_pkg::STAT_FORCE;
      lmtc_pkg::ADDR_SCY:  read_data = scy_r;
      lmtc_pkg::ADDR_SCX:  read_data = scx_r;
      lmtc_pkg::ADDR_LY:   read_data = control_r[7] ? seq_status.line : 8'd0;
      lmtc_pkg::ADDR_LYC:  read_data = lyc_r;
      lmtc_pkg::ADDR_BGP:  read_data = bgp_r;
      lmtc_pkg::ADDR_OBP0: read_data = obp0_r;
      lmtc_pkg::ADDR_OBP1: read_data = obp1_r;
      lmtc_pkg::ADDR_WY:   read_data = wy_r;
      lmtc_pkg::ADDR_WX:   read_data = wx_r;
      default:             read_data = lmtc_pkg::UNMAPPED_DATA;
    endcase
  end

endmodule

`default_nettype wire

// ===== rtl/lmtc_seq.sv =====
// Scanline and mode sequencer: countdown, line kinds, interrupt flags.
// Depends on lmtc_pkg; takes register values from lmtc_regs.
`default_nettype none

module lmtc_seq (
  input  wire                      clk,
  input  wire                      rst_n,
  input  wire                      tick_en,
  input  wire [7:0]                tick_cycles,
  input  wire                      restart,
  input  lmtc_pkg::lcd_regs_t      regs,
  output lmtc_pkg::seq_status_t    seq_status,
  output lmtc_pkg::tick_flags_t    flags
);

  logic [7:0]         line_r, line_nxt;
  logic [7:0]         seq_r, seq_nxt;
  logic [1:0]         kind_r, kind_nxt;
  logic signed [15:0] cd_r, cd_nxt;
  logic [1:0]         pend_r, pend_nxt;
  logic [1:0]         cur_r, cur_nxt;
  logic               match_r, match_nxt;

  logic signed [16:0] cd_diff;
  logic signed [15:0] cd_sat;
  logic               due;
  logic               st_mode;
  logic [7:0]         seq_inc;

  // Subtract elapsed cycles, saturate at the signed floor
  assign cd_diff = {cd_r[15], cd_r} - {9'd0, tick_cycles};
  assign cd_sat  = (cd_diff[16] && !cd_diff[15]) ? lmtc_pkg::CD_FLOOR : cd_diff[15:0];
  assign due     = cd_sat[15] || (cd_sat == 16'sd0);
  assign seq_inc = seq_r + 8'd1;

  // STAT request from entering a mode whose source is enabled
  assign st_mode =
      (cur_r != lmtc_pkg::MODE_VBLANK && pend_r == lmtc_pkg::MODE_VBLANK && regs.status[4])
   || (cur_r != lmtc_pkg::MODE_HBLANK && pend_r == lmtc_pkg::MODE_HBLANK && regs.status[3])
   || (cur_r != lmtc_pkg::MODE_OAM    && pend_r == lmtc_pkg::MODE_OAM    && regs.status[5]);

  // One transition per tick
  always_comb begin
    line_nxt  = line_r;
    seq_nxt   = seq_r;
    kind_nxt  = kind_r;
    cd_nxt    = cd_r;
    pend_nxt  = pend_r;
    cur_nxt   = cur_r;
    match_nxt = match_r;
    flags     = '0;
    if (restart) begin
      line_nxt = 8'd0;
      seq_nxt  = 8'd0;
      kind_nxt = lmtc_pkg::KIND_FIRST;
      pend_nxt = lmtc_pkg::MODE_OAM;
      cur_nxt  = lmtc_pkg::MODE_HBLANK;
    end else if (tick_en) begin
      if (tick_cycles != 8'd0) begin
        match_nxt = 1'b0;
      end
      cd_nxt = cd_sat;
      if (due) begin
        flags.stat_request = st_mode;
        cur_nxt = pend_r;
        unique case (kind_r)
          lmtc_pkg::KIND_LAST: begin
            if (pend_r == lmtc_pkg::MODE_VBLANK) begin
              line_nxt = 8'd0;
              cd_nxt   = cd_sat + lmtc_pkg::CD_LINE;
              pend_nxt = lmtc_pkg::MODE_HBLANK;
            end else if (pend_r == lmtc_pkg::MODE_HBLANK) begin
              cd_nxt   = cd_sat + lmtc_pkg::CD_STEP;
              pend_nxt = lmtc_pkg::MODE_OAM;
              seq_nxt  = 8'd0;
              kind_nxt = lmtc_pkg::KIND_FIRST;
            end
          end
          lmtc_pkg::KIND_FIRST: begin
            if (pend_r == lmtc_pkg::MODE_OAM) begin
              flags.render_request = 1'b1;
              flags.render_line    = line_r;
              cd_nxt   = cd_sat + lmtc_pkg::CD_OAM;
              pend_nxt = lmtc_pkg::MODE_XFER;
            end else if (pend_r == lmtc_pkg::MODE_XFER) begin
              cd_nxt   = cd_sat + lmtc_pkg::CD_XFER;
              pend_nxt = lmtc_pkg::MODE_HBLANK;
            end else if (pend_r == lmtc_pkg::MODE_HBLANK) begin
              cd_nxt   = cd_sat + lmtc_pkg::CD_HEND;
              seq_nxt  = seq_inc;
              kind_nxt = lmtc_pkg::KIND_NORMAL;
            end
          end
          lmtc_pkg::KIND_NORMAL: begin
            if (pend_r == lmtc_pkg::MODE_OAM) begin
              match_nxt = (line_r == regs.compare);
              cd_nxt    = cd_sat + lmtc_pkg::CD_OAM;
              pend_nxt  = lmtc_pkg::MODE_XFER;
            end else if (pend_r == lmtc_pkg::MODE_XFER) begin
              cd_nxt   = cd_sat + lmtc_pkg::CD_XFER;
              pend_nxt = lmtc_pkg::MODE_HBLANK;
            end else if (pend_r == lmtc_pkg::MODE_HBLANK && seq_r == line_r) begin
              cd_nxt   = cd_sat + lmtc_pkg::CD_HEND;
              seq_nxt  = seq_inc;
              kind_nxt = (seq_inc < lmtc_pkg::LINE_VBLANK) ? lmtc_pkg::KIND_NORMAL
                                                           : lmtc_pkg::KIND_VBLANK;
            end else if (pend_r == lmtc_pkg::MODE_HBLANK) begin
              line_nxt = line_r + 8'd1;
              flags.render_request = 1'b1;
              flags.render_line    = line_r + 8'd1;
              cd_nxt   = cd_sat + lmtc_pkg::CD_STEP;
              pend_nxt = lmtc_pkg::MODE_OAM;
            end
          end
          lmtc_pkg::KIND_VBLANK: begin
            if (pend_r == lmtc_pkg::MODE_HBLANK) begin
              line_nxt = line_r + 8'd1;
              cd_nxt   = cd_sat + lmtc_pkg::CD_STEP;
              pend_nxt = lmtc_pkg::MODE_VBLANK;
              // Entering vblank drops the mode-change STAT request
              if (line_r + 8'd1 == lmtc_pkg::LINE_VBLANK) begin
                flags.vblank_request = regs.control[7];
                flags.stat_request   = 1'b0;
                flags.frame_done     = 1'b1;
              end
            end else if (pend_r == lmtc_pkg::MODE_VBLANK && seq_r == line_r) begin
              cd_nxt  = cd_sat + lmtc_pkg::CD_LINE;
              seq_nxt = seq_inc;
            end else if (pend_r == lmtc_pkg::MODE_VBLANK) begin
              line_nxt = line_r + 8'd1;
              cd_nxt   = cd_sat + lmtc_pkg::CD_STEP;
              kind_nxt = (seq_r < lmtc_pkg::LINE_LAST_SEQ) ? lmtc_pkg::KIND_VBLANK
                                                           : lmtc_pkg::KIND_LAST;
            end
          end
          default: ;
        endcase
      end
      // LYC match keeps raising STAT while enabled
      if (match_nxt && regs.status[6]) begin
        flags.stat_request = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      line_r  <= 8'd0;
      seq_r   <= lmtc_pkg::SEQ_RESET;
      kind_r  <= lmtc_pkg::KIND_LAST;
      cd_r    <= lmtc_pkg::CD_RESET;
      pend_r  <= lmtc_pkg::MODE_HBLANK;
      cur_r   <= lmtc_pkg::MODE_HBLANK;
      match_r <= 1'b0;
    end else begin
      line_r  <= line_nxt;
      seq_r   <= seq_nxt;
      kind_r  <= kind_nxt;
      cd_r    <= cd_nxt;
      pend_r  <= pend_nxt;
      cur_r   <= cur_nxt;
      match_r <= match_nxt;
    end
  end

  assign seq_status.line  = line_r;
  assign seq_status.mode  = cur_r;
  assign seq_status.match = match_r;

endmodule

`default_nettype wire

// ===== rtl/lcd_mode_timing_controller.sv =====
// LCD mode timing controller: input register, register file, sequencer, result register.
// Depends on lmtc_pkg, lmtc_regs and lmtc_seq.
//
// Usage:
//   Input words arrive on in_tvalid/in_tready/in_tdata/in_tuser; in_tuser selects
//   a tick, a register write or a register read. Every accepted word produces
//   exactly one result word on out_tvalid/out_tready/out_tdata, in order.
//   A word is acted on while it sits in the input register: the register file and
//   the sequencer finish it in that same cycle and load the result register, so
//   out_tvalid rises once the result register is loaded. Throughput is one word per
//   cycle while the output is not stalled; the sequencer state update for one word
//   is a single compare/add pass, so the next word already sees the updated state.
//   While the receiver holds out_tready low, the result register holds its word
//   and one more word may wait in the input register; in_tready falls only when
//   both are full.
//   Synchronous active-low reset loads the register reset values (control 0x91,
//   status 0x81, background palette 0xE4), puts the sequencer on the last line
//   with a countdown of 80 and empties both pipeline registers.
`default_nettype none

module lcd_mode_timing_controller (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         in_tvalid,
  output logic        in_tready,
  input  wire  [31:0] in_tdata,   // bus_address[15:0], write_data[23:16], tick_cycles[31:24]
  input  wire  [1:0]  in_tuser,   // action[1:0]
  output logic        out_tvalid,
  input  wire         out_tready,
  output logic [23:0] out_tdata   // read_data[7:0], vblank_request[8], stat_request[9],
                                  // render_request[10], render_line[18:11], frame_done[19],
                                  // zero[23:20]
);

  logic                   s1_valid_r, s1_valid_nxt;
  lmtc_pkg::item_t        s1_item_r;
  logic                   out_valid_r, out_valid_nxt;
  logic [23:0]            out_data_r;

  logic                   advance;
  logic                   proc;
  logic                   in_fire;
  logic [7:0]             rd_data;
  logic                   restart;
  lmtc_pkg::lcd_regs_t    regs;
  lmtc_pkg::seq_status_t  seq_status;
  lmtc_pkg::tick_flags_t  flags;
  lmtc_pkg::tick_flags_t  res_flags;
  logic [7:0]             res_read;

  // Handshake: result register frees when empty or taken
  assign advance   = !out_valid_r || out_tready;
  assign proc      = s1_valid_r && advance;
  assign in_tready = !s1_valid_r || advance;
  assign in_fire   = in_tvalid && in_tready;

  assign s1_valid_nxt  = in_fire || (s1_valid_r && !advance);
  assign out_valid_nxt = proc || (out_valid_r && !out_tready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Capture the input word
  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_item_r.action      <= in_tuser;
      s1_item_r.bus_address <= in_tdata[15:0];
      s1_item_r.write_data  <= in_tdata[23:16];
      s1_item_r.tick_cycles <= in_tdata[31:24];
    end
  end

  lmtc_regs u_regs (
    .clk        (clk),
    .rst_n      (rst_n),
    .wr_en      (proc && s1_item_r.action == lmtc_pkg::ACT_WRITE),
    .addr       (s1_item_r.bus_address),
    .wdata      (s1_item_r.write_data),
    .seq_status (seq_status),
    .regs       (regs),
    .restart    (restart),
    .read_data  (rd_data)
  );

  lmtc_seq u_seq (
    .clk         (clk),
    .rst_n       (rst_n),
    .tick_en     (proc && s1_item_r.action == lmtc_pkg::ACT_TICK),
    .tick_cycles (s1_item_r.tick_cycles),
    .restart     (restart),
    .regs        (regs),
    .seq_status  (seq_status),
    .flags       (flags)
  );

  // Select result fields by item kind
  assign res_read  = (s1_item_r.action == lmtc_pkg::ACT_READ) ? rd_data : 8'd0;
  assign res_flags = (s1_item_r.action == lmtc_pkg::ACT_TICK) ? flags : '0;

  always_ff @(posedge clk) begin
    if (proc) begin
      out_data_r <= {4'd0, res_flags.frame_done, res_flags.render_line,
                     res_flags.render_request, res_flags.stat_request,
                     res_flags.vblank_request, res_read};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // A frame completion never coincides with a line render
  a_frame_no_render: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[19] |-> !out_tdata[10])
    else $error("frame_done together with render_request");

  // Vblank request only comes with frame completion
  a_vblank_frame: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[8] |-> out_tdata[19])
    else $error("vblank_request without frame_done");

  // Render line is zero unless a render is flagged
  a_render_line: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tdata[10] |-> out_tdata[18:11] == 8'd0)
    else $error("render_line set without render_request");

  // A processed word always lands in the result register
  a_proc_loads: assert property (@(posedge clk) disable iff (!rst_n)
    proc |=> out_tvalid)
    else $error("processed word lost");

endmodule

`default_nettype wire

// ===== sim/lcd_mode_timing_controller_test.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for lcd_mode_timing_controller: register map, enable reset,
// line/mode sequencing and interrupt flags under random stream stalls.
// Depends on lmtc_pkg and the controller RTL.

module lcd_mode_timing_controller_test;
  import lmtc_pkg::*;

  localparam logic [1:0] ACT_UNUSED  = 2'd3;
  localparam int         CYCLE_LIMIT = 200_000;
  localparam int         DRAIN_WAIT  = 8;

  // Result word as it sits on out_tdata, most significant field first
  typedef struct packed {
    logic [3:0] pad;
    logic       frame_done;
    logic [7:0] render_line;
    logic       render_request;
    logic       stat_request;
    logic       vblank_request;
    logic [7:0] read_data;
  } timing_word_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [31:0] in_tdata = '0;  // bus_address[15:0], write_data[23:16], tick_cycles[31:24]
  logic [1:0]  in_tuser = '0;  // action[1:0]
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [23:0] out_tdata;      // read_data[7:0], vblank[8], stat[9], render_req[10],
                               // render_line[18:11], frame_done[19], zero[23:20]

  int unsigned send_idle_pct = 23;
  int unsigned recv_idle_pct = 60;
  int unsigned mismatch_count = 0;
  int unsigned cycle_count = 0;

  timing_word_t timing_results_q[$];

  // Shadow of the controller state
  logic [7:0] lcdc_q, stat_q, scy_q, scx_q, lyc_q;
  logic [7:0] bgp_q, obp0_q, obp1_q, wy_q, wx_q;
  logic [7:0] ly_q, seq_line_q;
  logic [1:0] kind_q, next_mode_q, mode_q;
  logic       coincidence_q;
  int         countdown_q;

  lcd_mode_timing_controller i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // Abort a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // Stall the result channel at random
  always @(negedge clk) begin
    out_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Compare each accepted result word with the oldest expected one
  always @(posedge clk) begin
    timing_word_t got, want;
    if (rst_n && out_tvalid && out_tready) begin
      got = timing_word_t'(out_tdata);
      if (timing_results_q.size() == 0) begin
        $error("unexpected result word %h", out_tdata);
        mismatch_count++;
      end else begin
        want = timing_results_q.pop_front();
        if (got.read_data !== want.read_data) begin
          $error("read_data: expected %h, got %h", want.read_data, got.read_data);
          mismatch_count++;
        end
        if (got.vblank_request !== want.vblank_request) begin
          $error("vblank_request: expected %b, got %b", want.vblank_request,
                 got.vblank_request);
          mismatch_count++;
        end
        if (got.stat_request !== want.stat_request) begin
          $error("stat_request: expected %b, got %b", want.stat_request, got.stat_request);
          mismatch_count++;
        end
        if (got.render_request !== want.render_request) begin
          $error("render_request: expected %b, got %b", want.render_request,
                 got.render_request);
          mismatch_count++;
        end
        if (got.render_line !== want.render_line) begin
          $error("render_line: expected %0d, got %0d", want.render_line, got.render_line);
          mismatch_count++;
        end
        if (got.frame_done !== want.frame_done) begin
          $error("frame_done: expected %b, got %b", want.frame_done, got.frame_done);
          mismatch_count++;
        end
        if (got.pad !== want.pad) begin
          $error("pad: expected %h, got %h", want.pad, got.pad);
          mismatch_count++;
        end
      end
    end
  end

  task automatic reset_lcd_shadow();
    lcdc_q        = CONTROL_RESET;
    stat_q        = STATUS_RESET;
    scy_q         = '0;
    scx_q         = '0;
    lyc_q         = '0;
    bgp_q         = BGP_RESET;
    obp0_q        = '0;
    obp1_q        = '0;
    wy_q          = '0;
    wx_q          = '0;
    ly_q          = '0;
    seq_line_q    = SEQ_RESET;
    kind_q        = KIND_LAST;
    countdown_q   = CD_RESET;
    next_mode_q   = MODE_HBLANK;
    mode_q        = MODE_HBLANK;
    coincidence_q = 1'b0;
  endtask

  // Apply one accepted word to the shadow state and queue the result it yields
  task automatic step_lcd_timing(input item_t w);
    timing_word_t r;
    r = '0;
    case (w.action)
      ACT_TICK: begin
        if (w.tick_cycles != 0) coincidence_q = 1'b0;
        countdown_q -= int'(w.tick_cycles);
        if (countdown_q < CD_FLOOR) countdown_q = CD_FLOOR;
        if (countdown_q <= 0) begin
          // Mode-entry interrupts, judged before the mode moves on
          if (mode_q != MODE_VBLANK && next_mode_q == MODE_VBLANK && stat_q[4])
            r.stat_request = 1'b1;
          if (mode_q != MODE_HBLANK && next_mode_q == MODE_HBLANK && stat_q[3])
            r.stat_request = 1'b1;
          if (mode_q != MODE_OAM && next_mode_q == MODE_OAM && stat_q[5])
            r.stat_request = 1'b1;
          mode_q = next_mode_q;
          case (kind_q)
            KIND_LAST: begin
              if (next_mode_q == MODE_VBLANK) begin
                ly_q = '0;
                countdown_q += CD_LINE;
                next_mode_q = MODE_HBLANK;
              end else if (next_mode_q == MODE_HBLANK) begin
                countdown_q += CD_STEP;
                next_mode_q = MODE_OAM;
                seq_line_q = '0;
                kind_q = KIND_FIRST;
              end
            end
            KIND_FIRST: begin
              if (next_mode_q == MODE_OAM) begin
                r.render_request = 1'b1;
                r.render_line = ly_q;
                countdown_q += CD_OAM;
                next_mode_q = MODE_XFER;
              end else if (next_mode_q == MODE_XFER) begin
                countdown_q += CD_XFER;
                next_mode_q = MODE_HBLANK;
              end else if (next_mode_q == MODE_HBLANK) begin
                countdown_q += CD_HEND;
                seq_line_q++;
                kind_q = KIND_NORMAL;
              end
            end
            KIND_NORMAL: begin
              if (next_mode_q == MODE_OAM) begin
                coincidence_q = (ly_q == lyc_q);
                countdown_q += CD_OAM;
                next_mode_q = MODE_XFER;
              end else if (next_mode_q == MODE_XFER) begin
                countdown_q += CD_XFER;
                next_mode_q = MODE_HBLANK;
              end else if (next_mode_q == MODE_HBLANK && seq_line_q == ly_q) begin
                countdown_q += CD_HEND;
                seq_line_q++;
                kind_q = (seq_line_q < LINE_VBLANK) ? KIND_NORMAL : KIND_VBLANK;
              end else if (next_mode_q == MODE_HBLANK) begin
                ly_q++;
                r.render_request = 1'b1;
                r.render_line = ly_q;
                countdown_q += CD_STEP;
                next_mode_q = MODE_OAM;
              end
            end
            default: begin
              // Vblank line; entering line 144 masks this tick's mode interrupt
              if (next_mode_q == MODE_HBLANK) begin
                ly_q++;
                countdown_q += CD_STEP;
                next_mode_q = MODE_VBLANK;
                if (ly_q == LINE_VBLANK) begin
                  r.vblank_request = lcdc_q[7];
                  r.stat_request = 1'b0;
                  r.frame_done = 1'b1;
                end
              end else if (next_mode_q == MODE_VBLANK && seq_line_q == ly_q) begin
                countdown_q += CD_LINE;
                seq_line_q++;
              end else if (next_mode_q == MODE_VBLANK) begin
                ly_q++;
                countdown_q += CD_STEP;
                kind_q = (seq_line_q < LINE_LAST_SEQ) ? KIND_VBLANK : KIND_LAST;
              end
            end
          endcase
        end
        if (coincidence_q && stat_q[6]) r.stat_request = 1'b1;
      end
      ACT_WRITE: begin
        case (w.bus_address)
          ADDR_LCDC: begin
            // Rising display enable restarts the line sequencer
            if (!lcdc_q[7] && w.write_data[7]) begin
              ly_q        = '0;
              seq_line_q  = '0;
              kind_q      = KIND_FIRST;
              next_mode_q = MODE_OAM;
              mode_q      = MODE_HBLANK;
            end
            lcdc_q = w.write_data;
          end
          ADDR_STAT: stat_q = w.write_data;
          ADDR_SCY:  scy_q  = w.write_data;
          ADDR_SCX:  scx_q  = w.write_data;
          ADDR_LYC:  lyc_q  = w.write_data;
          ADDR_BGP:  bgp_q  = w.write_data;
          ADDR_OBP0: obp0_q = w.write_data;
          ADDR_OBP1: obp1_q = w.write_data;
          ADDR_WY:   wy_q   = w.write_data;
          ADDR_WX:   wx_q   = w.write_data;
          default: ;
        endcase
      end
      ACT_READ: begin
        case (w.bus_address)
          ADDR_LCDC: r.read_data = lcdc_q;
          ADDR_STAT: r.read_data = (stat_q & STAT_RMASK) | {5'b0, coincidence_q, mode_q}
                                   | STAT_FORCE;
          ADDR_SCY:  r.read_data = scy_q;
          ADDR_SCX:  r.read_data = scx_q;
          ADDR_LY:   r.read_data = lcdc_q[7] ? ly_q : 8'h00;
          ADDR_LYC:  r.read_data = lyc_q;
          ADDR_BGP:  r.read_data = bgp_q;
          ADDR_OBP0: r.read_data = obp0_q;
          ADDR_OBP1: r.read_data = obp1_q;
          ADDR_WY:   r.read_data = wy_q;
          ADDR_WX:   r.read_data = wx_q;
          default:   r.read_data = UNMAPPED_DATA;
        endcase
      end
      default: ;
    endcase
    timing_results_q.push_back(r);
  endtask

  // Offer one word at a falling edge and hold it until accepted; returns at a falling edge
  task automatic send_lcd_word(input logic [1:0] action, input logic [15:0] addr,
                               input logic [7:0] data, input logic [7:0] cycles);
    item_t w;
    w.action      = action;
    w.bus_address = addr;
    w.write_data  = data;
    w.tick_cycles = cycles;
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {cycles, data, addr};
    in_tuser  <= action;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    step_lcd_timing(w);
    @(negedge clk);
  endtask

  // Read every decoded address as reset left it, plus unmapped ones
  task automatic test_reset_values();
    for (int a = ADDR_LCDC; a <= ADDR_WX; a++) send_lcd_word(ACT_READ, 16'(a), 8'h00, 8'h00);
    send_lcd_word(ACT_READ, 16'hFFFF, 8'h00, 8'h00);
  endtask

  // Read-only line register, ignored words, status bits and tick extremes
  task automatic test_register_corners();
    send_lcd_word(ACT_WRITE, ADDR_LY, 8'h5A, 8'h00);
    send_lcd_word(ACT_READ, ADDR_LY, 8'h00, 8'h00);
    send_lcd_word(ACT_WRITE, 16'h0000, 8'hFF, 8'hFF);
    send_lcd_word(ACT_UNUSED, 16'hFFFF, 8'hFF, 8'hFF);
    send_lcd_word(ACT_WRITE, ADDR_STAT, 8'hFF, 8'h00);
    send_lcd_word(ACT_READ, ADDR_STAT, 8'h00, 8'h00);
    send_lcd_word(ACT_WRITE, ADDR_LYC, 8'h00, 8'h00);
    send_lcd_word(ACT_TICK, 16'h0000, 8'h00, 8'h00);
    send_lcd_word(ACT_TICK, 16'hFFFF, 8'hFF, 8'hFF);
  endtask

  // Display off gates the line register; turning it back on restarts the sequencer
  task automatic test_display_enable();
    send_lcd_word(ACT_WRITE, ADDR_LCDC, 8'h00, 8'h00);
    send_lcd_word(ACT_READ, ADDR_LY, 8'h00, 8'h00);
    send_lcd_word(ACT_WRITE, ADDR_LCDC, 8'hFF, 8'h00);
    send_lcd_word(ACT_READ, ADDR_STAT, 8'h00, 8'h00);
  endtask

  // Mostly large ticks so frames complete, mixed with register traffic and noise
  task automatic test_random_traffic(input int unsigned n_words);
    logic [1:0]  action;
    logic [15:0] addr;
    logic [7:0]  data;
    logic [7:0]  cycles;
    int unsigned roll;
    for (int i = 0; i < n_words; i++) begin
      action = ACT_TICK;
      addr   = 16'($urandom);
      data   = 8'($urandom);
      cycles = 8'($urandom);
      roll   = $urandom_range(99);
      if (roll < 72) begin
        roll = $urandom_range(99);
        if (roll < 70) cycles = 8'($urandom_range(255, 128));
        else if (roll < 90) cycles = 8'($urandom_range(31));
      end else if (roll < 84) begin
        action = ACT_READ;
        if ($urandom_range(99) < 80) addr = ADDR_LCDC + 16'($urandom_range(11));
      end else if (roll < 97) begin
        action = ACT_WRITE;
        roll = $urandom_range(99);
        if (roll < 8) begin
          addr = ADDR_LCDC;
          if ($urandom_range(99) < 85) data[7] = 1'b1;
        end else if (roll < 80) begin
          addr = ADDR_LCDC + 16'($urandom_range(11, 1));
          if (addr == ADDR_LYC && $urandom_range(99) < 80) data = 8'($urandom_range(153));
        end
      end else begin
        action = ACT_UNUSED;
      end
      send_lcd_word(action, addr, data, cycles);
    end
  endtask

  initial begin
    reset_lcd_shadow();
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_reset_values();
    test_register_corners();
    test_display_enable();
    test_random_traffic(300);
    send_idle_pct = 60;
    recv_idle_pct = 23;
    test_random_traffic(300);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_traffic(300);

    // Drain outstanding results
    in_tvalid <= 1'b0;
    while (timing_results_q.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
